>>> hw/rtl/altbl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altbl_pkg: shared definitions for the array list table engine
// Request kinds, result status codes, word width and default capacity.
// ----------------------------------------------------------------------------
package altbl_pkg;

    localparam int WORD_W       = 32;
    localparam int CAPACITY_DEF = 128;

    localparam logic [2:0] KIND_INS  = 3'd0;
    localparam logic [2:0] KIND_DEL  = 3'd1;
    localparam logic [2:0] KIND_SRCH = 3'd2;
    localparam logic [2:0] KIND_MTF  = 3'd3;
    localparam logic [2:0] KIND_TRN  = 3'd4;
    localparam logic [2:0] KIND_SORT = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

endpackage

>>> hw/rtl/altbl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altbl_ram: entry store of the array list table engine
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module altbl_ram import altbl_pkg::*; #(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/array_list_table_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_table_engine: self-organizing packed list of signed words
// Insert/delete at a position, linear search (plain, move-to-front,
// transposition) and ordered insert over one entry store.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: i_in_valid / o_in_stall carry kind, position and
//   item_value. A transaction is taken when valid is high and stall low.
//   Result channel: o_out_valid / i_out_stall carry status, found_position,
//   removed_word and entry_count; one result per request, in order.
//   One request is worked at a time; o_in_stall stays high until it is done.
//   Shift and scan stream one entry per cycle through the single store port
//   pair. Insert and delete shift the entries between the position and the
//   tail, a search reads from the head up to the hit or the tail, and
//   move-to-front and transposition then swap the hit with its partner by one
//   read and two writes. Ordered insert shifts the larger entries up from the
//   tail. Error requests go straight to the result step.
//   The next request can be taken in the cycle after the result loads.
//   The result sits in an output register; the next request is taken while
//   it waits, and that request holds at its last step until the result
//   register frees up under i_out_stall.
//   Synchronous reset empties the list; stored words are not cleared.
// ----------------------------------------------------------------------------
module array_list_table_engine import altbl_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [2:0]               i_kind,
    input  logic [7:0]               i_position,
    input  logic signed [WORD_W-1:0] i_item_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_status,
    output logic [6:0]               o_found_position,
    output logic signed [WORD_W-1:0] o_removed_word,
    output logic [7:0]               o_entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 8) ? CW : 8;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SHR  = 4'd1;
    localparam logic [3:0] S_SHL  = 4'd2;
    localparam logic [3:0] S_SCAN = 4'd3;
    localparam logic [3:0] S_SWRD = 4'd4;
    localparam logic [3:0] S_SWW1 = 4'd5;
    localparam logic [3:0] S_SWW2 = 4'd6;
    localparam logic [3:0] S_SORT = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]        r_state, n_state;
    logic [2:0]        r_kind, n_kind;
    logic [AW-1:0]     r_pos, n_pos;
    logic [WORD_W-1:0] r_key, n_key;
    logic [CW-1:0]     r_ptr, n_ptr;
    logic              r_pend, n_pend;
    logic [AW-1:0]     r_paddr, n_paddr;
    logic [AW-1:0]     r_hit, n_hit;
    logic [1:0]        r_status, n_status;
    logic [AW-1:0]     r_place, n_place;
    logic [WORD_W-1:0] r_removed, n_removed;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_ncount, n_ncount;

    logic              r_ovalid, n_ovalid;
    logic [1:0]        r_ostatus, n_ostatus;
    logic [6:0]        r_oplace, n_oplace;
    logic [WORD_W-1:0] r_oremoved, n_oremoved;
    logic [7:0]        r_ocount, n_ocount;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [WORD_W-1:0] mem_rdata;

    logic              in_acc;
    logic              out_free;
    logic [XW-1:0]     pos_x;
    logic [XW-1:0]     cnt_x;
    logic              cnt_full;
    logic [AW-1:0]     partner;
    logic              key_hit;
    logic              sort_stop;

    altbl_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign in_acc    = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_ovalid || !i_out_stall;
    assign pos_x     = XW'(i_position);
    assign cnt_x     = XW'(r_count);
    assign cnt_full  = (r_count == CW'(CAPACITY));
    assign partner   = (r_kind == KIND_MTF) ? '0 : AW'(r_hit - AW'(1));
    assign key_hit   = r_pend && (mem_rdata == r_key);
    assign sort_stop = r_pend && !($signed(mem_rdata) > $signed(r_key));

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_pos      = r_pos;
        n_key      = r_key;
        n_ptr      = r_ptr;
        n_pend     = 1'b0;
        n_paddr    = r_paddr;
        n_hit      = r_hit;
        n_status   = r_status;
        n_place    = r_place;
        n_removed  = r_removed;
        n_count    = r_count;
        n_ncount   = r_ncount;
        n_ovalid   = r_ovalid && i_out_stall;
        n_ostatus  = r_ostatus;
        n_oplace   = r_oplace;
        n_oremoved = r_oremoved;
        n_ocount   = r_ocount;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_raddr  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_kind    = i_kind;
                    n_key     = i_item_value;
                    n_pos     = AW'(i_position);
                    n_status  = ST_OK;
                    n_place   = '0;
                    n_removed = '0;
                    n_ncount  = r_count;
                    n_state   = S_DONE;
                    unique case (i_kind)
                        KIND_INS: begin
                            if (pos_x > cnt_x) begin
                                n_status = ST_RANGE;
                            end else if (cnt_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_ptr    = r_count;
                                n_place  = AW'(i_position);
                                n_ncount = r_count + CW'(1);
                                n_state  = S_SHR;
                            end
                        end
                        KIND_DEL: begin
                            if (pos_x >= cnt_x) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_ptr    = CW'(i_position);
                                n_place  = AW'(i_position);
                                n_ncount = r_count - CW'(1);
                                n_state  = S_SHL;
                            end
                        end
                        KIND_SRCH, KIND_MTF, KIND_TRN: begin
                            n_ptr   = '0;
                            n_state = S_SCAN;
                        end
                        KIND_SORT: begin
                            if (cnt_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_ptr    = r_count;
                                n_ncount = r_count + CW'(1);
                                n_state  = S_SORT;
                            end
                        end
                        default: begin
                            n_status = ST_RANGE;
                        end
                    endcase
                end
            end
            S_SHR: begin
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_paddr + AW'(1);
                    mem_wdata = mem_rdata;
                end
                if (r_ptr > CW'(r_pos)) begin
                    mem_raddr = AW'(r_ptr - CW'(1));
                    n_pend    = 1'b1;
                    n_paddr   = AW'(r_ptr - CW'(1));
                    n_ptr     = r_ptr - CW'(1);
                end else if (!r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos;
                    mem_wdata = r_key;
                    n_state   = S_DONE;
                end
            end
            S_SHL: begin
                if (r_pend) begin
                    if (r_paddr == r_pos) begin
                        n_removed = mem_rdata;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = r_paddr - AW'(1);
                        mem_wdata = mem_rdata;
                    end
                end
                if (r_ptr < r_count) begin
                    mem_raddr = AW'(r_ptr);
                    n_pend    = 1'b1;
                    n_paddr   = AW'(r_ptr);
                    n_ptr     = r_ptr + CW'(1);
                end else if (!r_pend) begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (key_hit) begin
                    n_hit   = r_paddr;
                    n_place = r_paddr;
                    if ((r_kind == KIND_MTF || r_kind == KIND_TRN) && r_paddr != '0) begin
                        n_state = S_SWRD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (r_ptr < r_count) begin
                    mem_raddr = AW'(r_ptr);
                    n_pend    = 1'b1;
                    n_paddr   = AW'(r_ptr);
                    n_ptr     = r_ptr + CW'(1);
                end else if (!r_pend) begin
                    n_status = ST_MISS;
                    n_place  = '0;
                    n_state  = S_DONE;
                end
            end
            S_SWRD: begin
                mem_raddr = partner;
                n_state   = S_SWW1;
            end
            S_SWW1: begin
                mem_we    = 1'b1;
                mem_waddr = r_hit;
                mem_wdata = mem_rdata;
                n_state   = S_SWW2;
            end
            S_SWW2: begin
                mem_we    = 1'b1;
                mem_waddr = partner;
                mem_wdata = r_key;
                n_state   = S_DONE;
            end
            S_SORT: begin
                if (sort_stop) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_paddr + AW'(1);
                    mem_wdata = r_key;
                    n_place   = r_paddr + AW'(1);
                    n_state   = S_DONE;
                end else begin
                    if (r_pend) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_paddr + AW'(1);
                        mem_wdata = mem_rdata;
                    end
                    if (r_ptr != '0) begin
                        mem_raddr = AW'(r_ptr - CW'(1));
                        n_pend    = 1'b1;
                        n_paddr   = AW'(r_ptr - CW'(1));
                        n_ptr     = r_ptr - CW'(1);
                    end else if (!r_pend) begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = r_key;
                        n_place   = '0;
                        n_state   = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_ovalid   = 1'b1;
                    n_ostatus  = r_status;
                    n_oplace   = 7'(r_place);
                    n_oremoved = r_removed;
                    n_ocount   = 8'(r_ncount);
                    n_count    = r_ncount;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend   <= 1'b0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pend   <= n_pend;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_pos      <= n_pos;
        r_key      <= n_key;
        r_ptr      <= n_ptr;
        r_paddr    <= n_paddr;
        r_hit      <= n_hit;
        r_status   <= n_status;
        r_place    <= n_place;
        r_removed  <= n_removed;
        r_ncount   <= n_ncount;
        r_ostatus  <= n_ostatus;
        r_oplace   <= n_oplace;
        r_oremoved <= n_oremoved;
        r_ocount   <= n_ocount;
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_ovalid;
    assign o_status         = r_ostatus;
    assign o_found_position = r_oplace;
    assign o_removed_word   = r_oremoved;
    assign o_entry_count    = r_ocount;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_found_position == '0 && o_removed_word == '0))
        else $error("failed transaction carries position or removed word");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("accepted transaction did not start work");

    a_pend_streaming: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_SHR || r_state == S_SHL || r_state == S_SCAN ||
                    r_state == S_SORT))
        else $error("read in flight outside a streaming step");

    a_count_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> ($past(r_state) == S_DONE))
        else $error("entry count changed outside result load");
`endif

endmodule
